@@ design/pswsc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Per-scope window statistics: shared package
// Payload types, the per-scope state row, function and word codes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pswsc_pkg;

    // Scope identifiers are 6 bits wide, so at most this many scopes exist.
    localparam int NUM_SLOTS = 64;

    // The percentile rank divides by 100 through a scaled reciprocal; the
    // result is exact for every dividend below 2**17.
    localparam int RANK_RECIP = 167773;
    localparam int RANK_SHIFT = 24;

    localparam logic [2:0] FUNC_BEGIN  = 3'd0;
    localparam logic [2:0] FUNC_ADD_T  = 3'd1;
    localparam logic [2:0] FUNC_ADD_A  = 3'd2;
    localparam logic [2:0] FUNC_END    = 3'd3;
    localparam logic [2:0] FUNC_QUERY  = 3'd4;
    localparam logic [2:0] FUNC_COMMIT = 3'd5;

    localparam logic [3:0] WORD_LAST_TIME  = 4'd0;
    localparam logic [3:0] WORD_AVG        = 4'd1;
    localparam logic [3:0] WORD_P95        = 4'd2;
    localparam logic [3:0] WORD_PEAK       = 4'd3;
    localparam logic [3:0] WORD_REP_TIME   = 4'd4;
    localparam logic [3:0] WORD_REP_CALLS  = 4'd5;
    localparam logic [3:0] WORD_REP_QUO    = 4'd6;
    localparam logic [3:0] WORD_TOT_CALLS  = 4'd7;
    localparam logic [3:0] WORD_LAST_CALLS = 4'd8;
    localparam logic [3:0] WORD_ALLOC_CNT  = 4'd9;
    localparam logic [3:0] WORD_FREE_CNT   = 4'd10;
    localparam logic [3:0] WORD_BYTES_ALOC = 4'd11;
    localparam logic [3:0] WORD_BYTES_FREE = 4'd12;
    localparam logic [3:0] WORD_FRAME      = 4'd13;

    localparam logic [1:0] DIV_AVG = 2'd1;
    localparam logic [1:0] DIV_QUO = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [5:0]  scope_id;
        logic [31:0] elapsed_us;
        logic [31:0] alloc_count_delta;
        logic [31:0] free_count_delta;
        logic [31:0] bytes_alloc_delta;
        logic [31:0] bytes_freed_delta;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  word_id;
        logic [63:0] value;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [63:0]      frame_time;
        logic [31:0]      frame_calls;
        logic [3:0][63:0] frame_alloc;
        logic [3:0][63:0] last_alloc;
        logic [31:0]      last_time;
        logic [31:0]      last_calls;
        logic [31:0]      peak_time;
        logic [63:0]      total_time;
        logic [63:0]      total_calls;
        logic [63:0]      base_time;
        logic [63:0]      base_calls;
    } row_t;

    typedef struct packed {
        logic       load;
        logic       row_read;
        logic       row_write;
        logic       wzero;
        logic       row_inc;
        logic       q_init;
        logic       walk_init;
        logic       walk_step;
        logic       bit_step;
        logic       div_start;
        logic [1:0] div_sel;
        logic       frame_inc;
        logic       out_load;
        logic [3:0] word;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       item_ok;
        logic       row_last;
        logic       n_zero;
        logic       walk_last;
        logic       bit_last;
        logic       div_done;
    } status_t;

endpackage
`default_nettype wire

@@ design/pswsc_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Per-scope window statistics: iterative divider
// Restoring 64-bit unsigned divider, one quotient bit per cycle. A zero
// divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module pswsc_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [63:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] dv_reg;
    logic        zero_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [64:0] rem_shift;
    logic [64:0] rem_sub;
    logic        fits;

    assign rem_shift = {rem_reg, quo_reg[63]};
    assign rem_sub   = rem_shift - {1'b0, dv_reg};
    assign fits      = rem_shift >= {1'b0, dv_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dv_reg   <= divisor;
            zero_reg <= (divisor == 64'd0);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[63:0] : rem_shift[63:0];
            quo_reg <= {quo_reg[62:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? 64'd0 : quo_reg;
endmodule
`default_nettype wire

@@ design/pswsc_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Per-scope window statistics: datapath
// Scope state memory, history ring, window walk with radix selection for the
// percentile, the shared divider and the result register.
// ----------------------------------------------------------------------------
module pswsc_dp #(
    parameter int SCOPES = 64,
    parameter int WINDOW = 128
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pswsc_pkg::in_item_t  item_in,
    input  wire pswsc_pkg::cmd_t      cmd,
    output pswsc_pkg::status_t        status,
    output pswsc_pkg::out_item_t      out_data
);
    import pswsc_pkg::*;

    localparam int NS   = (SCOPES < NUM_SLOTS) ? SCOPES : NUM_SLOTS;
    localparam int RW   = (NS > 1) ? $clog2(NS) : 1;
    localparam int PW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW   = $clog2(WINDOW + 1);
    localparam int RD   = NS * WINDOW;
    localparam int RA_W = (RD > 1) ? $clog2(RD) : 1;
    localparam int SW   = 32 + FW;
    localparam int KW   = FW + 7;

    row_t             row_mem  [NS];
    logic [FW-1:0]    fill_mem [NS];
    logic [PW-1:0]    pos_mem  [NS];
    logic [31:0]      ring_mem [RD];

    in_item_t         item_reg;
    logic [RW-1:0]    row_addr_reg;
    row_t             row_q;
    logic [FW-1:0]    fill_q;
    logic [PW-1:0]    pos_q;
    logic [63:0]      frame_number_reg;
    logic [PW-1:0]    j_reg;
    logic             rd_v_reg;
    logic [31:0]      ring_q;
    logic [FW-1:0]    cnt_reg;
    logic [SW-1:0]    sum_reg;
    logic [31:0]      pfx_reg;
    logic [31:0]      mask_reg;
    logic [FW-1:0]    krem_reg;
    logic [4:0]       bit_reg;
    logic [63:0]      avg_reg;
    logic [63:0]      quo_reg;
    logic [1:0]       div_sel_reg;
    out_item_t        out_reg;

    row_t             row_next;
    logic [FW-1:0]    fill_next;
    logic [PW-1:0]    pos_next;
    logic [31:0]      sat_t;
    logic [PW-1:0]    wr_pos;
    logic [RA_W-1:0]  ring_base;
    logic [KW-1:0]    kprod;
    logic [KW+17:0]   kscaled;
    logic [63:0]      rep_time;
    logic [63:0]      rep_calls;
    logic [63:0]      div_dd;
    logic [63:0]      div_dv;
    logic             div_done;
    logic [63:0]      div_q;
    logic             match;
    logic [63:0]      word_val;

    assign ring_base = RA_W'(row_addr_reg) * RA_W'(WINDOW);
    assign sat_t     = (|row_q.frame_time[63:32]) ? 32'hFFFF_FFFF : row_q.frame_time[31:0];
    assign wr_pos    = ({1'b0, pos_q} >= (PW+1)'(WINDOW)) ? '0 : pos_q;
    assign rep_time  = row_q.total_time - row_q.base_time;
    assign rep_calls = row_q.total_calls - row_q.base_calls;
    assign kprod     = KW'(fill_q - FW'(1)) * KW'(95);
    assign kscaled   = (KW+18)'(kprod) * (KW+18)'(RANK_RECIP);
    assign match     = ((ring_q & mask_reg) == pfx_reg) && !ring_q[bit_reg];

    // Next row contents for the write that follows a read of the same row, or an all-zero row when clearing.
    always_comb
    begin
        row_next  = row_q;
        fill_next = fill_q;
        pos_next  = pos_q;
        if (cmd.wzero)
        begin
            row_next  = '0;
            fill_next = '0;
            pos_next  = '0;
        end
        else
        begin
            case (item_reg.func)
                FUNC_BEGIN:
                begin
                    row_next.frame_time  = '0;
                    row_next.frame_calls = '0;
                    row_next.frame_alloc = '0;
                end
                FUNC_ADD_T:
                begin
                    row_next.frame_time  = row_q.frame_time + 64'(item_reg.elapsed_us);
                    row_next.frame_calls = row_q.frame_calls + 32'd1;
                end
                FUNC_ADD_A:
                begin
                    row_next.frame_alloc[0] = row_q.frame_alloc[0]
                                            + 64'(item_reg.alloc_count_delta);
                    row_next.frame_alloc[1] = row_q.frame_alloc[1]
                                            + 64'(item_reg.free_count_delta);
                    row_next.frame_alloc[2] = row_q.frame_alloc[2]
                                            + 64'(item_reg.bytes_alloc_delta);
                    row_next.frame_alloc[3] = row_q.frame_alloc[3]
                                            + 64'(item_reg.bytes_freed_delta);
                end
                FUNC_END:
                begin
                    row_next.last_time   = sat_t;
                    row_next.last_calls  = row_q.frame_calls;
                    row_next.total_time  = row_q.total_time + row_q.frame_time;
                    row_next.total_calls = row_q.total_calls + 64'(row_q.frame_calls);
                    row_next.peak_time   = (sat_t > row_q.peak_time) ? sat_t : row_q.peak_time;
                    row_next.last_alloc  = row_q.frame_alloc;
                    pos_next  = (({1'b0, wr_pos} + (PW+1)'(1)) == (PW+1)'(WINDOW))
                              ? '0 : wr_pos + PW'(1);
                    fill_next = (fill_q < FW'(WINDOW)) ? fill_q + FW'(1) : fill_q;
                end
                FUNC_COMMIT:
                begin
                    row_next.base_time  = row_q.total_time;
                    row_next.base_calls = row_q.total_calls;
                end
                default:
                begin
                    row_next = row_q;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_write)
        begin
            row_mem[row_addr_reg]  <= row_next;
            fill_mem[row_addr_reg] <= fill_next;
            pos_mem[row_addr_reg]  <= pos_next;
        end
        if (cmd.row_read)
        begin
            row_q  <= row_mem[row_addr_reg];
            fill_q <= fill_mem[row_addr_reg];
            pos_q  <= pos_mem[row_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_write && !cmd.wzero && (item_reg.func == FUNC_END))
        begin
            ring_mem[ring_base + RA_W'(wr_pos)] <= sat_t;
        end
        if (cmd.walk_step)
        begin
            ring_q <= ring_mem[ring_base + RA_W'(j_reg)];
        end
    end

    always_comb
    begin
        case (div_sel_reg)
            DIV_AVG: begin div_dd = 64'(sum_reg);  div_dv = 64'(fill_q);  end
            default: begin div_dd = rep_time;      div_dv = rep_calls;     end
        endcase
    end

    // The operand select is held in a register so the divider sees it at start.
    logic div_go_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_go_reg <= 1'b0;
        end
        else
        begin
            div_go_reg <= cmd.div_start;
        end
    end

    pswsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (div_dd),
        .divisor  (div_dv),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_addr_reg     <= '0;
            frame_number_reg <= '0;
            rd_v_reg         <= 1'b0;
            div_sel_reg      <= DIV_AVG;
        end
        else
        begin
            rd_v_reg <= cmd.walk_step;
            if (cmd.load)
            begin
                if ((item_in.func == FUNC_ADD_T) || (item_in.func == FUNC_ADD_A)
                    || (item_in.func == FUNC_QUERY))
                begin
                    row_addr_reg <= item_in.scope_id[RW-1:0];
                end
                else
                begin
                    row_addr_reg <= '0;
                end
            end
            else if (cmd.row_inc)
            begin
                row_addr_reg <= row_addr_reg + RW'(1);
            end
            if (cmd.frame_inc)
            begin
                frame_number_reg <= frame_number_reg + 64'd1;
            end
            if (cmd.div_start)
            begin
                div_sel_reg <= cmd.div_sel;
            end
        end
    end

    always_comb
    begin
        case (cmd.word)
            WORD_LAST_TIME:  word_val = 64'(row_q.last_time);
            WORD_AVG:        word_val = avg_reg;
            WORD_P95:        word_val = 64'(pfx_reg);
            WORD_PEAK:       word_val = 64'(row_q.peak_time);
            WORD_REP_TIME:   word_val = rep_time;
            WORD_REP_CALLS:  word_val = rep_calls;
            WORD_REP_QUO:    word_val = quo_reg;
            WORD_TOT_CALLS:  word_val = row_q.total_calls;
            WORD_LAST_CALLS: word_val = 64'(row_q.last_calls);
            WORD_ALLOC_CNT:  word_val = row_q.last_alloc[0];
            WORD_FREE_CNT:   word_val = row_q.last_alloc[1];
            WORD_BYTES_ALOC: word_val = row_q.last_alloc[2];
            WORD_BYTES_FREE: word_val = row_q.last_alloc[3];
            WORD_FRAME:      word_val = frame_number_reg;
            default:         word_val = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item_in;
        end
        if (rd_v_reg)
        begin
            cnt_reg <= cnt_reg + FW'(match);
            if (bit_reg == 5'd31)
            begin
                sum_reg <= sum_reg + SW'(ring_q);
            end
        end
        if (cmd.walk_init)
        begin
            j_reg   <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.walk_step)
        begin
            j_reg <= j_reg + PW'(1);
        end
        if (cmd.q_init)
        begin
            sum_reg  <= '0;
            pfx_reg  <= '0;
            mask_reg <= '0;
            bit_reg  <= 5'd31;
            krem_reg <= kscaled[RANK_SHIFT +: FW];
        end
        if (cmd.bit_step)
        begin
            if (krem_reg >= cnt_reg)
            begin
                pfx_reg[bit_reg] <= 1'b1;
                krem_reg         <= krem_reg - cnt_reg;
            end
            mask_reg[bit_reg] <= 1'b1;
            bit_reg           <= bit_reg - 5'd1;
        end
        if (div_done)
        begin
            case (div_sel_reg)
                DIV_AVG: avg_reg <= div_q;
                default: quo_reg <= div_q;
            endcase
        end
        if (cmd.out_load)
        begin
            out_reg.word_id <= cmd.word;
            out_reg.value   <= word_val;
            out_reg.last    <= (cmd.word == WORD_FRAME);
        end
    end

    assign status.func      = item_reg.func;
    assign status.item_ok   = {1'b0, item_reg.scope_id} < 7'(NS);
    assign status.row_last  = (row_addr_reg == RW'(NS - 1));
    assign status.n_zero    = (fill_q == '0);
    assign status.walk_last = (FW'(j_reg) == (fill_q - FW'(1)));
    assign status.bit_last  = (bit_reg == 5'd0);
    assign status.div_done  = div_done;
    assign out_data         = out_reg;
endmodule
`default_nettype wire

@@ design/pswsc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Per-scope window statistics: controller
// Sequences the clearing pass, scope sweeps, single-scope updates, the query
// walk and the result beats.
// ----------------------------------------------------------------------------
module pswsc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    input  wire pswsc_pkg::status_t status,
    output pswsc_pkg::cmd_t         cmd
);
    import pswsc_pkg::*;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_RD    = 5'd3;
    localparam logic [4:0] S_WR    = 5'd4;
    localparam logic [4:0] S_SW_RD = 5'd5;
    localparam logic [4:0] S_SW_WR = 5'd6;
    localparam logic [4:0] S_QCHK  = 5'd7;
    localparam logic [4:0] S_WALK  = 5'd10;
    localparam logic [4:0] S_DRAIN = 5'd11;
    localparam logic [4:0] S_BIT   = 5'd12;
    localparam logic [4:0] S_AVG   = 5'd13;
    localparam logic [4:0] S_AVGW  = 5'd14;
    localparam logic [4:0] S_QUO   = 5'd15;
    localparam logic [4:0] S_QUOW  = 5'd16;
    localparam logic [4:0] S_EMIT  = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [3:0] word_reg;
    logic [3:0] word_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        word_next  = word_reg;
        req_ready  = 1'b0;
        cmd.word   = word_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.row_write = 1'b1;
                cmd.wzero     = 1'b1;
                if (status.row_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.row_inc = 1'b1;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (status.func)
                    FUNC_BEGIN, FUNC_END, FUNC_COMMIT:
                        state_next = S_SW_RD;
                    FUNC_ADD_T, FUNC_ADD_A, FUNC_QUERY:
                        state_next = status.item_ok ? S_RD : S_IDLE;
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_RD:
            begin
                cmd.row_read = 1'b1;
                state_next   = (status.func == FUNC_QUERY) ? S_QCHK : S_WR;
            end
            S_WR:
            begin
                cmd.row_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_SW_RD:
            begin
                cmd.row_read = 1'b1;
                state_next   = S_SW_WR;
            end
            S_SW_WR:
            begin
                cmd.row_write = 1'b1;
                if (status.row_last)
                begin
                    cmd.frame_inc = (status.func == FUNC_END);
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.row_inc = 1'b1;
                    state_next  = S_SW_RD;
                end
            end
            S_QCHK:
            begin
                cmd.q_init = 1'b1;
                if (status.n_zero)
                begin
                    state_next = S_AVG;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_BIT;
            end
            S_BIT:
            begin
                cmd.bit_step = 1'b1;
                if (status.bit_last)
                begin
                    state_next = S_AVG;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_WALK;
                end
            end
            S_AVG:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_AVG;
                state_next    = S_AVGW;
            end
            S_AVGW:
            begin
                if (status.div_done)
                begin
                    state_next = S_QUO;
                end
            end
            S_QUO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_QUO;
                state_next    = S_QUOW;
            end
            S_QUOW:
            begin
                if (status.div_done)
                begin
                    word_next  = WORD_LAST_TIME;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    word_next    = word_reg + 4'd1;
                    if (word_reg == WORD_FRAME)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            word_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
endmodule
`default_nettype wire

@@ design/per_scope_window_statistics_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Per-scope window statistics: top level
// Frame-based performance counters kept per scope, with a history window,
// a 95th percentile selection and report snapshots.
// ----------------------------------------------------------------------------
// After reset the block clears the state row of every scope (at most 64)
// before it accepts the first beat. Each request beat carries one
// operation. Add operations read the state row of their scope and write it
// back. Begin frame, end frame and commit report sweep every scope with a
// read and a write of its state row. A query returns fourteen result beats.
// The percentile is found by the window walk one bit per pass over the
// history ring, which is read one entry per cycle, with a drain step and a
// bit step after each pass to settle the bit. The percentile rank comes
// from a reciprocal multiplication, and the window average and the time
// per call share one bit-serial 64-bit divider. With an empty window the
// walk is skipped. The response side has its own output register, so a new
// request is taken while the last result beat still waits. Scope numbers at
// or above SCOPES are ignored by add operations and give no result from a
// query.
// ----------------------------------------------------------------------------
module per_scope_window_statistics_top #(
    parameter int SCOPES = 64,
    parameter int WINDOW = 128
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire pswsc_pkg::in_item_t  req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output pswsc_pkg::out_item_t      rsp
);
    import pswsc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The controller owns all sequencing; the datapath only follows commands.
    pswsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // State memories, the history ring and the result register.
    pswsc_dp #(
        .SCOPES (SCOPES),
        .WINDOW (WINDOW)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (req),
        .cmd      (cmd),
        .status   (status),
        .out_data (rsp)
    );
endmodule
`default_nettype wire
